// ===== design/bss_pkg.sv =====
package bss_pkg;

   // Default number of server slots that the block is built for.
   localparam int MAX_SERVERS_DEFAULT = 8;

   // Widths fixed by the request and response fields.
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 3;
   localparam int CONN_W   = 16;
   localparam int LOAD_W   = 7;
   localparam int ACTIVE_W = 4;
   localparam int POLICY_W = 2;
   localparam int METRIC_W = 16;

   // Largest value the active server count register can hold.
   localparam int ACTIVE_MAX = 15;

   // Number of slots that a set command can reach through its slot field.
   localparam int SLOT_REACH = 8;

   // Resource loads are clamped to this percentage.
   localparam logic [LOAD_W-1:0] LOAD_LIMIT = 7'd100;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_SELECT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET_CONN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET_LOAD = 2'd2;

   // Selection policies.
   localparam logic [POLICY_W-1:0] POLICY_ROUND_ROBIN = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_LEAST_CONN  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_LEAST_LOAD  = 2'd2;

   // Configuration register indexes.
   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_ACTIVE = 1'b1;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Largest number of servers that can take part in a selection.
   function automatic int eff_max(input int max_servers);
      return (max_servers < ACTIVE_MAX) ? max_servers : ACTIVE_MAX;
   endfunction

   // Number of slots that hold stored values.
   function automatic int store_depth(input int max_servers);
      return (max_servers < SLOT_REACH) ? max_servers : SLOT_REACH;
   endfunction

   // Width of an index over the servers taking part.
   function automatic int ptr_width(input int max_servers);
      return (eff_max(max_servers) > 1) ? $clog2(eff_max(max_servers)) : 1;
   endfunction

   // Width of a count of servers taking part.
   function automatic int count_width(input int max_servers);
      return $clog2(eff_max(max_servers) + 1);
   endfunction

   // Write request from the sequencer to the server table.
   typedef struct packed {
      logic              conn_en;
      logic              load_en;
      logic [SLOT_W-1:0] slot;
      logic [CONN_W-1:0] conn;
      logic [LOAD_W-1:0] cpu;
      logic [LOAD_W-1:0] mem;
   } store_write_type;

endpackage

// ===== design/bss_store.sv =====
module bss_store #(
   parameter int MAX_SERVERS = bss_pkg::MAX_SERVERS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  bss_pkg::store_write_type                    wr,
   input  logic                                        rd_conn,
   input  logic [bss_pkg::ptr_width(MAX_SERVERS)-1:0]  rd_idx,
   output logic [bss_pkg::METRIC_W-1:0]                rd_metric
);

   localparam int DEPTH = bss_pkg::store_depth(MAX_SERVERS);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [bss_pkg::CONN_W-1:0] conn_ff [DEPTH];
   logic [bss_pkg::CONN_W-1:0] conn_in [DEPTH];
   logic [bss_pkg::LOAD_W-1:0] cpu_ff  [DEPTH];
   logic [bss_pkg::LOAD_W-1:0] cpu_in  [DEPTH];
   logic [bss_pkg::LOAD_W-1:0] mem_ff  [DEPTH];
   logic [bss_pkg::LOAD_W-1:0] mem_in  [DEPTH];

   logic [bss_pkg::LOAD_W-1:0] cpu_clamped;
   logic [bss_pkg::LOAD_W-1:0] mem_clamped;
   logic                       slot_ok;
   logic [IDX_W-1:0]           wr_idx;
   logic [IDX_W-1:0]           rd_sel;
   logic [bss_pkg::LOAD_W:0]   load_sum;

   // Clamp incoming loads and decide whether the slot exists.
   always_comb begin
      cpu_clamped = (wr.cpu > bss_pkg::LOAD_LIMIT) ? bss_pkg::LOAD_LIMIT : wr.cpu;
      mem_clamped = (wr.mem > bss_pkg::LOAD_LIMIT) ? bss_pkg::LOAD_LIMIT : wr.mem;
      slot_ok     = (int'(wr.slot) < DEPTH);
      wr_idx      = wr.slot[IDX_W-1:0];
   end

   // Next table contents: one slot is written per update request.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         conn_in[i] = conn_ff[i];
         cpu_in[i]  = cpu_ff[i];
         mem_in[i]  = mem_ff[i];
      end
      if (slot_ok && wr.conn_en) begin
         conn_in[wr_idx] = wr.conn;
      end
      if (slot_ok && wr.load_en) begin
         cpu_in[wr_idx] = cpu_clamped;
         mem_in[wr_idx] = mem_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            conn_ff[i] <= '0;
            cpu_ff[i]  <= '0;
            mem_ff[i]  <= '0;
         end
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            conn_ff[i] <= conn_in[i];
            cpu_ff[i]  <= cpu_in[i];
            mem_ff[i]  <= mem_in[i];
         end
      end
   end

   // Shared read port: the connection count or the summed load of one slot.
   // Slots that no request can reach always read as zero.
   always_comb begin
      rd_sel    = rd_idx[IDX_W-1:0];
      load_sum  = (bss_pkg::LOAD_W + 1)'(cpu_ff[rd_sel])
                + (bss_pkg::LOAD_W + 1)'(mem_ff[rd_sel]);
      rd_metric = '0;
      if (int'(rd_idx) < DEPTH) begin
         rd_metric = rd_conn ? conn_ff[rd_sel] : bss_pkg::METRIC_W'(load_sum);
      end
   end

endmodule

// ===== design/backend_server_selector.sv =====
// Backend server selector. Each request is either a select, which returns
// one chosen server index on rsp_chosen_server with a one-cycle rsp_valid
// strobe, or an update of a slot's connection count or load pair, which
// returns nothing. Update requests and round robin selects need no scan:
// the block stays ready and the response follows the accepting edge. A
// least connection or least load select reads one stored server per cycle
// through a single table read port and comparator, so busy stays high
// while each active server is read in turn (one to eight with the default
// size) and the response strobes in the cycle after the last comparison.
// The response cannot be held off: it must be captured in its strobe cycle.
// Configuration writes are meant for idle periods only.
module backend_server_selector #(
   parameter int MAX_SERVERS = bss_pkg::MAX_SERVERS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bss_pkg::CMD_W-1:0]       req_command,
   input  logic [bss_pkg::SLOT_W-1:0]      req_server_slot,
   input  logic [bss_pkg::CONN_W-1:0]      req_connection_value,
   input  logic [bss_pkg::LOAD_W-1:0]      req_cpu_value,
   input  logic [bss_pkg::LOAD_W-1:0]      req_memory_value,
   output logic                            rsp_valid,
   output logic [bss_pkg::SLOT_W-1:0]      rsp_chosen_server,
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [bss_pkg::ACTIVE_W-1:0]    csr_wdata
);

   localparam int EFF_MAX = bss_pkg::eff_max(MAX_SERVERS);
   localparam int PTR_W   = bss_pkg::ptr_width(MAX_SERVERS);
   localparam int CNT_W   = bss_pkg::count_width(MAX_SERVERS);
   localparam int SLOT_REACH_RESET = 8;

   bss_pkg::state_type state_ff, state_in;

   logic [bss_pkg::POLICY_W-1:0] policy_ff, policy_in;
   logic [bss_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [PTR_W-1:0]             ptr_ff, ptr_in;
   logic [PTR_W-1:0]             idx_ff, idx_in;
   logic [PTR_W-1:0]             best_ff, best_in;
   logic [bss_pkg::METRIC_W-1:0] low_ff, low_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bss_pkg::SLOT_W-1:0]   rsp_server_ff, rsp_server_in;

   logic [CNT_W-1:0]             eff;
   logic [PTR_W-1:0]             ptr_use;
   logic                         take;
   logic                         rd_conn;
   logic [bss_pkg::METRIC_W-1:0] metric;
   bss_pkg::store_write_type     wr;

   // Server table with its shared read port.
   bss_store #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .rd_conn   (rd_conn),
      .rd_idx    (idx_ff),
      .rd_metric (metric)
   );

   // Number of servers taking part: zero counts as one, and the count
   // saturates at the built size or at fifteen, whichever is lower.
   always_comb begin
      if (active_ff == '0) begin
         eff = CNT_W'(1);
      end else if (int'(active_ff) > EFF_MAX) begin
         eff = CNT_W'(EFF_MAX);
      end else begin
         eff = CNT_W'(active_ff);
      end
      ptr_use = (CNT_W'(ptr_ff) >= eff) ? '0 : ptr_ff;
      rd_conn = (policy_ff == bss_pkg::POLICY_LEAST_CONN);
      take    = (idx_ff == '0) || (metric < low_ff);
   end

   // Sequencer: next state, table writes and the response.
   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      active_in     = active_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      low_in        = low_ff;
      rsp_valid_in  = 1'b0;
      rsp_server_in = rsp_server_ff;
      wr            = '0;
      wr.slot       = req_server_slot;
      wr.conn       = req_connection_value;
      wr.cpu        = req_cpu_value;
      wr.mem        = req_memory_value;

      unique case (state_ff)
         bss_pkg::ST_IDLE: begin
            if (start) begin
               case (req_command)
                  bss_pkg::CMD_SELECT: begin
                     case (policy_ff)
                        bss_pkg::POLICY_ROUND_ROBIN: begin
                           rsp_valid_in  = 1'b1;
                           rsp_server_in = bss_pkg::SLOT_W'(ptr_use);
                           ptr_in = (CNT_W'(ptr_use) + CNT_W'(1) >= eff)
                                  ? '0 : ptr_use + PTR_W'(1);
                        end
                        bss_pkg::POLICY_LEAST_CONN,
                        bss_pkg::POLICY_LEAST_LOAD: begin
                           state_in = bss_pkg::ST_SCAN;
                           idx_in   = '0;
                           best_in  = '0;
                        end
                        default: begin
                           // Unused policy code answers server zero.
                           rsp_valid_in  = 1'b1;
                           rsp_server_in = '0;
                        end
                     endcase
                  end
                  bss_pkg::CMD_SET_CONN: begin
                     wr.conn_en = 1'b1;
                  end
                  bss_pkg::CMD_SET_LOAD: begin
                     wr.load_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         bss_pkg::ST_SCAN: begin
            // One stored server per cycle; ties keep the lower index.
            if (take) begin
               low_in  = metric;
               best_in = idx_ff;
            end
            if (CNT_W'(idx_ff) + CNT_W'(1) == eff) begin
               rsp_valid_in  = 1'b1;
               rsp_server_in = bss_pkg::SLOT_W'(take ? idx_ff : best_ff);
               state_in      = bss_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + PTR_W'(1);
            end
         end
         default: begin
            state_in = bss_pkg::ST_IDLE;
         end
      endcase

      // Register writes; a new active count restarts the rotation.
      if (csr_write) begin
         unique case (csr_index)
            bss_pkg::REG_POLICY: begin
               policy_in = csr_wdata[bss_pkg::POLICY_W-1:0];
            end
            bss_pkg::REG_ACTIVE: begin
               active_in = csr_wdata;
               ptr_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bss_pkg::ST_IDLE;
         policy_ff    <= bss_pkg::POLICY_ROUND_ROBIN;
         active_ff    <= bss_pkg::ACTIVE_W'(SLOT_REACH_RESET);
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         active_ff    <= active_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan and response payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      low_ff        <= low_in;
      rsp_server_ff <= rsp_server_in;
   end

   assign busy              = (state_ff == bss_pkg::ST_SCAN);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_server = rsp_server_ff;

endmodule

// ===== design/bss_checker.sv =====
module bss_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [bss_pkg::CMD_W-1:0]    req_command,
   input logic                         rsp_valid
);

   // A response only appears once the sequencer is free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while selector busy");

   // Update requests never produce a response.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != bss_pkg::CMD_SELECT) |=> !rsp_valid)
      else $error("response after an update request");

   // Update requests never occupy the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != bss_pkg::CMD_SELECT) |=> !busy)
      else $error("update request made the selector busy");

   // A scan starts without a response in flight.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_valid)
      else $error("response together with start of scan");

   // Every scan ends in a response.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("scan ended without a response");

endmodule

bind backend_server_selector bss_checker u_bss_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid)
);
